/* hdl/prp_pkg.sv */
// ----------------------------------------------------------------------------
// prp_pkg
// Shared types and constants of the pose-relative pinhole projector.
// ----------------------------------------------------------------------------
package prp_pkg;

    localparam int POS_W   = 32;
    localparam int QUAT_W  = 16;
    localparam int CFG_W   = 16;
    localparam int ROW_W   = 12;
    localparam int IDX_W   = 3;
    localparam int SLOT_W  = 4;
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DIV_W   = 36;
    localparam int QUO_W   = 32;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_POSE  = 1'b1;

    localparam logic [IDX_W-1:0] CFG_FOCAL_X    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_FOCAL_Y    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_CENTER_X   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_CENTER_Y   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_ROW_OFFSET = 3'd4;

    localparam logic [CFG_W-1:0] RST_FOCAL_X    = 16'd559;
    localparam logic [CFG_W-1:0] RST_FOCAL_Y    = 16'd558;
    localparam logic [CFG_W-1:0] RST_CENTER_X   = 16'd490;
    localparam logic [CFG_W-1:0] RST_CENTER_Y   = 16'd273;
    localparam logic [ROW_W-1:0] RST_ROW_OFFSET = 12'd180;

    // operand selection for the ten quaternion products, order x y z w
    localparam logic [1:0] QMUL_A [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0,
                                           2'd0, 2'd1, 2'd3, 2'd3, 2'd3};
    localparam logic [1:0] QMUL_B [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                           2'd2, 2'd2, 2'd0, 2'd1, 2'd2};

    // observer-frame products: step c forms rot[j][i] * e[j], c = 3i + j
    localparam logic [1:0] PM_I   [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1,
                                          2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] PM_J   [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
                                          2'd2, 2'd0, 2'd1, 2'd2};
    localparam logic [3:0] PM_ROT [9] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4,
                                          4'd7, 4'd2, 4'd5, 4'd8};

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [31:0] PIX_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PIX_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  rem_init;
        logic [QUO_W-1:0]  low_init;
        logic [DIV_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quot;
    } t_div_rsp;

endpackage

/* hdl/prp_mul.sv */
// ----------------------------------------------------------------------------
// prp_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module prp_mul
    import prp_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

/* hdl/prp_div.sv */
// ----------------------------------------------------------------------------
// prp_div
// Restoring radix-2 divider, one quotient bit per cycle, 32 bits per request.
// ----------------------------------------------------------------------------
module prp_div
    import prp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_req  i_req,
    output t_div_rsp  o_rsp
);

    logic [DIV_W-1:0] r_rem;
    logic [QUO_W-1:0] r_low;
    logic [QUO_W-1:0] r_quot;
    logic [DIV_W-1:0] r_div;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DIV_W:0]   shifted;
    logic             fits;

    assign shifted = {r_rem, r_low[QUO_W-1]};
    assign fits    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_rem  <= i_req.rem_init;
                r_low  <= i_req.low_init;
                r_div  <= i_req.divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? DIV_W'(shifted - {1'b0, r_div}) : DIV_W'(shifted);
                r_low  <= {r_low[QUO_W-2:0], 1'b0};
                r_quot <= {r_quot[QUO_W-2:0], fits};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

/* hdl/pose_relative_pinhole_projector_core.sv */
// ----------------------------------------------------------------------------
// pose_relative_pinhole_projector_core
// Projects stored target positions into pixel coordinates of an observer.
// ----------------------------------------------------------------------------
// A store request (opcode 0) is written straight into the target store. A pose
// request (opcode 1) runs through one shared multiplier and one 32-step divider
// under a sequencer, in this order:
// - the ten quaternion products;
// - nine divisions that normalise the rotation;
// - for each target, the observer-frame products;
// - for each axis of each target, the focal products and a division;
// - for each target, a load of the output register.
// A zero quaternion skips the normalisation and takes the identity rotation. A
// target behind the camera skips its focal products and divisions. A ratio out
// of range skips its division. A stalled output register holds the run at that
// target. The input is not ready during a pose run.
// Results leave through an output register, so a result may wait while the
// next request is taken.
module pose_relative_pinhole_projector_core
    import prp_pkg::*;
#(
    parameter int NUM_TARGETS = 3
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_opcode,
    input  logic [3:0]               i_target_index,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic signed [QUAT_W-1:0] i_quat_x,
    input  logic signed [QUAT_W-1:0] i_quat_y,
    input  logic signed [QUAT_W-1:0] i_quat_z,
    input  logic signed [QUAT_W-1:0] i_quat_w,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [SLOT_W-1:0]        o_slot,
    output logic signed [POS_W-1:0]  o_pixel_u,
    output logic signed [POS_W-1:0]  o_pixel_v,
    output logic                     o_behind_camera,
    output logic                     o_last
);

    localparam int KW = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_QMUL = 7'b0000010,
        S_RDIV = 7'b0000100,
        S_PMUL = 7'b0001000,
        S_FMUL = 7'b0010000,
        S_PDIV = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state;

    logic [CFG_W-1:0] r_focal_x, r_focal_y, r_center_x, r_center_y;
    logic [ROW_W-1:0] r_row_offset;

    logic signed [POS_W-1:0]  r_store [NUM_TARGETS][3];
    logic signed [POS_W-1:0]  r_pos [3];
    logic signed [QUAT_W-1:0] r_quat [4];
    logic signed [31:0]       r_sq [10];
    logic signed [31:0]       r_rot [9];
    logic signed [36:0]       r_d [3];
    logic [52:0]              r_a;
    logic [3:0]               r_cnt;
    logic [SLOT_W-1:0]        r_k;
    logic                     r_ax;
    logic                     r_dwait;
    logic signed [POS_W-1:0]  r_u, r_v;
    logic                     r_behind;

    logic                     r_out_valid;
    logic [SLOT_W-1:0]        r_out_slot;
    logic signed [POS_W-1:0]  r_out_u, r_out_v;
    logic                     r_out_behind, r_out_last;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    logic                     in_acc;
    logic                     out_free;

    // quaternion numerators
    logic signed [34:0] num [9];
    logic [32:0]        norm_sum;
    logic signed [34:0] num_sel;
    logic [32:0]        num_mag;
    logic               norm_zero;

    // projection datapath
    logic signed [36:0] d_ax;
    logic [35:0]        mag;
    logic               neg;
    logic [CFG_W-1:0]   focal;
    logic [35:0]        z;
    logic               ovf;
    logic [34:0]        q_fin;
    logic signed [35:0] sq;
    logic signed [37:0] pix_full;
    logic signed [31:0] pix;
    logic               fin;
    logic [1:0]         pj;
    logic signed [33:0] diff;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        logic signed [34:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
        xx = 35'(r_sq[0]);
        yy = 35'(r_sq[1]);
        zz = 35'(r_sq[2]);
        ww = 35'(r_sq[3]);
        xy = 35'(r_sq[4]);
        xz = 35'(r_sq[5]);
        yz = 35'(r_sq[6]);
        wx = 35'(r_sq[7]);
        wy = 35'(r_sq[8]);
        wz = 35'(r_sq[9]);
        num[0] = ww + xx - yy - zz;
        num[1] = (xy - wz) <<< 1;
        num[2] = (xz + wy) <<< 1;
        num[3] = (xy + wz) <<< 1;
        num[4] = ww - xx + yy - zz;
        num[5] = (yz - wx) <<< 1;
        num[6] = (xz - wy) <<< 1;
        num[7] = (yz + wx) <<< 1;
        num[8] = ww - xx - yy + zz;
        norm_sum = 33'(xx + yy + zz + ww);
    end

    assign norm_zero = (norm_sum == '0);
    assign num_sel   = (r_cnt < 4'd9) ? num[r_cnt] : '0;
    assign num_mag   = num_sel[34] ? 33'(-num_sel) : 33'(num_sel);

    assign d_ax  = r_ax ? r_d[2] : r_d[1];
    assign neg   = (d_ax > 0);
    assign mag   = d_ax[36] ? 36'(-d_ax) : 36'(d_ax);
    assign focal = r_ax ? r_focal_y : r_focal_x;
    assign z     = r_d[0][35:0];
    assign ovf   = r_a >= {1'b0, z, 16'b0};
    assign q_fin = ovf ? 35'h4_0000_0000 : {3'b0, div_rsp.quot};
    assign sq    = neg ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});

    always_comb begin
        pix_full = 38'(sq) + $signed({6'b0, (r_ax ? r_center_y : r_center_x), 16'b0});
        if (r_ax) begin
            pix_full = pix_full - $signed({10'b0, r_row_offset, 16'b0});
        end
        if (pix_full > 38'(PIX_MAX)) begin
            pix = PIX_MAX;
        end else if (pix_full < 38'(PIX_MIN)) begin
            pix = PIX_MIN;
        end else begin
            pix = pix_full[31:0];
        end
    end

    assign fin = (r_state == S_PDIV) && ((!r_dwait && ovf) || (r_dwait && div_rsp.done));

    // shared multiplier operands
    assign pj   = (r_cnt < 4'd9) ? PM_J[r_cnt] : 2'd0;
    assign diff = 34'(r_store[r_k[KW-1:0]][pj]) - 34'(r_pos[pj]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_QMUL: begin
                if (r_cnt < 4'd10) begin
                    mul_a = 34'(r_quat[QMUL_A[r_cnt]]);
                    mul_b = 34'(r_quat[QMUL_B[r_cnt]]);
                end
            end
            S_PMUL: begin
                if (r_cnt < 4'd9) begin
                    mul_a = 34'(r_rot[PM_ROT[r_cnt]]);
                    mul_b = diff;
                end
            end
            S_FMUL: begin
                mul_a = (r_cnt == 4'd0) ? $signed({17'b0, mag[16:0]})
                                        : $signed({15'b0, mag[35:17]});
                mul_b = $signed({18'b0, focal});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider request
    always_comb begin
        div_req = '0;
        case (r_state)
            S_RDIV: begin
                div_req.start    = !r_dwait && !norm_zero;
                div_req.rem_init = 36'(num_mag[32:2]);
                div_req.low_init = {num_mag[1:0], 30'b0};
                div_req.divisor  = 36'(norm_sum);
            end
            S_PDIV: begin
                div_req.start    = !r_dwait && !ovf;
                div_req.rem_init = r_a[51:16];
                div_req.low_init = {r_a[15:0], 16'b0};
                div_req.divisor  = z;
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    prp_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    prp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_k          <= '0;
            r_ax         <= 1'b0;
            r_dwait      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_focal_x    <= RST_FOCAL_X;
            r_focal_y    <= RST_FOCAL_Y;
            r_center_x   <= RST_CENTER_X;
            r_center_y   <= RST_CENTER_Y;
            r_row_offset <= RST_ROW_OFFSET;
            for (int t = 0; t < NUM_TARGETS; t++) begin
                for (int c = 0; c < 3; c++) begin
                    r_store[t][c] <= '0;
                end
            end
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FOCAL_X:    r_focal_x    <= i_cfg_data;
                    CFG_FOCAL_Y:    r_focal_y    <= i_cfg_data;
                    CFG_CENTER_X:   r_center_x   <= i_cfg_data;
                    CFG_CENTER_Y:   r_center_y   <= i_cfg_data;
                    CFG_ROW_OFFSET: r_row_offset <= i_cfg_data[ROW_W-1:0];
                    default: begin
                    end
                endcase
            end

            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_opcode == OP_POSE) begin
                            r_pos[0]  <= i_pos_x;
                            r_pos[1]  <= i_pos_y;
                            r_pos[2]  <= i_pos_z;
                            r_quat[0] <= i_quat_x;
                            r_quat[1] <= i_quat_y;
                            r_quat[2] <= i_quat_z;
                            r_quat[3] <= i_quat_w;
                            r_cnt     <= '0;
                            r_state   <= S_QMUL;
                        end else if (5'(i_target_index) < 5'(NUM_TARGETS)) begin
                            r_store[i_target_index[KW-1:0]][0] <= i_pos_x;
                            r_store[i_target_index[KW-1:0]][1] <= i_pos_y;
                            r_store[i_target_index[KW-1:0]][2] <= i_pos_z;
                        end
                    end
                end
                S_QMUL: begin
                    if (r_cnt != 4'd0) begin
                        r_sq[r_cnt - 4'd1] <= prod[31:0];
                    end
                    if (r_cnt == 4'd10) begin
                        r_cnt   <= '0;
                        r_dwait <= 1'b0;
                        r_state <= S_RDIV;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_RDIV: begin
                    if (norm_zero) begin
                        for (int e = 0; e < 9; e++) begin
                            r_rot[e] <= (e % 4 == 0) ? ONE_Q30 : '0;
                        end
                        r_cnt   <= '0;
                        r_k     <= '0;
                        r_d[0]  <= '0;
                        r_d[1]  <= '0;
                        r_d[2]  <= '0;
                        r_state <= S_PMUL;
                    end else if (!r_dwait) begin
                        r_dwait <= 1'b1;
                    end else if (div_rsp.done) begin
                        r_rot[r_cnt] <= num_sel[34] ? -$signed(div_rsp.quot)
                                                    : $signed(div_rsp.quot);
                        r_dwait <= 1'b0;
                        if (r_cnt == 4'd8) begin
                            r_cnt   <= '0;
                            r_k     <= '0;
                            r_d[0]  <= '0;
                            r_d[1]  <= '0;
                            r_d[2]  <= '0;
                            r_state <= S_PMUL;
                        end else begin
                            r_cnt <= r_cnt + 4'd1;
                        end
                    end
                end
                S_PMUL: begin
                    if (r_cnt != 4'd0) begin
                        r_d[PM_I[r_cnt - 4'd1]] <= r_d[PM_I[r_cnt - 4'd1]]
                                                   + $signed(prod[66:30]);
                    end
                    if (r_cnt == 4'd9) begin
                        r_cnt <= '0;
                        r_ax  <= 1'b0;
                        if (r_d[0] <= 0) begin
                            r_behind <= 1'b1;
                            r_u      <= PIX_MAX;
                            r_v      <= PIX_MAX;
                            r_state  <= S_OUT;
                        end else begin
                            r_behind <= 1'b0;
                            r_state  <= S_FMUL;
                        end
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_FMUL: begin
                    if (r_cnt == 4'd1) begin
                        r_a <= 53'(prod[33:0]);
                    end
                    if (r_cnt == 4'd2) begin
                        r_a     <= r_a + {prod[35:0], 17'b0};
                        r_dwait <= 1'b0;
                        r_state <= S_PDIV;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_PDIV: begin
                    if (!r_dwait && !ovf) begin
                        r_dwait <= 1'b1;
                    end
                    if (fin) begin
                        r_dwait <= 1'b0;
                        if (!r_ax) begin
                            r_u     <= pix;
                            r_ax    <= 1'b1;
                            r_cnt   <= '0;
                            r_state <= S_FMUL;
                        end else begin
                            r_v     <= pix;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_slot   <= r_k;
                        r_out_u      <= r_u;
                        r_out_v      <= r_v;
                        r_out_behind <= r_behind;
                        r_out_last   <= (r_k == SLOT_W'(NUM_TARGETS - 1));
                        if (r_k == SLOT_W'(NUM_TARGETS - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 4'd1;
                            r_cnt   <= '0;
                            r_d[0]  <= '0;
                            r_d[1]  <= '0;
                            r_d[2]  <= '0;
                            r_state <= S_PMUL;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_slot          = r_out_slot;
    assign o_pixel_u       = r_out_u;
    assign o_pixel_v       = r_out_v;
    assign o_behind_camera = r_out_behind;
    assign o_last          = r_out_last;

endmodule

/* hdl/prp_chk.sv */
// ----------------------------------------------------------------------------
// prp_chk
// Port-level checks of the projector, bound to the top level.
// ----------------------------------------------------------------------------
module prp_chk
    import prp_pkg::*;
#(
    parameter int NUM_TARGETS = 3
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     o_in_ready,
    input  logic                     i_opcode,
    input  logic                     o_out_valid,
    input  logic                     i_out_ready,
    input  logic [SLOT_W-1:0]        o_slot,
    input  logic signed [POS_W-1:0]  o_pixel_u,
    input  logic signed [POS_W-1:0]  o_pixel_v,
    input  logic                     o_behind_camera,
    input  logic                     o_last
);

    // nothing leaves straight after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an accepted pose request closes the input
    a_pose_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_opcode == OP_POSE) |=> !o_in_ready)
        else $error("input ready during pose run");

    // a target behind the camera reports saturated pixels
    a_behind_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_behind_camera |->
            (o_pixel_u == PIX_MAX) && (o_pixel_v == PIX_MAX))
        else $error("behind camera without saturated pixels");

    // last marks exactly the final slot
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_slot == SLOT_W'(NUM_TARGETS - 1))))
        else $error("last flag on wrong slot");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_slot) && $stable(o_pixel_u) && $stable(o_pixel_v))
        else $error("stalled result changed");

endmodule

bind pose_relative_pinhole_projector_core prp_chk #(
    .NUM_TARGETS (NUM_TARGETS)
) u_prp_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_opcode        (i_opcode),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_slot          (o_slot),
    .o_pixel_u       (o_pixel_u),
    .o_pixel_v       (o_pixel_v),
    .o_behind_camera (o_behind_camera),
    .o_last          (o_last)
);

/* tb/sv/pose_relative_pinhole_projector_core_tb.sv */
// ----------------------------------------------------------------------------
// pose_relative_pinhole_projector_core_tb
// Stores target positions, sends observer poses and checks every projected
// pixel against an in-bench fixed-point model, under random idling on both
// handshakes, output back-pressure and several camera settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pose_relative_pinhole_projector_core_tb;
    import prp_pkg::*;

    localparam int N_TGT      = 3;
    localparam int MAX_CYCLES = 3_000_000;
    localparam int DRAIN_WAIT = 40;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic behind;
        logic is_last;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_opcode = OP_STORE;
    logic [3:0] i_target_index = '0;
    logic signed [POS_W-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [QUAT_W-1:0] i_quat_x = '0, i_quat_y = '0, i_quat_z = '0, i_quat_w = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [SLOT_W-1:0] o_slot;
    logic signed [POS_W-1:0] o_pixel_u, o_pixel_v;
    logic o_behind_camera, o_last;

    pose_relative_pinhole_projector_core #(.NUM_TARGETS(N_TGT)) DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // camera settings and target store as the block should hold them
    logic [15:0] focal_x, focal_y, center_x, center_y;
    logic [11:0] row_offset;
    longint targets [N_TGT][3];
    t_pixel pixel_q [$];

    int errors = 0;
    int cycles = 0;
    int max_gap = 18;
    int hold_cycles = 0;

    function automatic longint sat32(longint val);
        if (val > 64'sd2147483647) return 64'sd2147483647;
        if (val < -64'sd2147483648) return -64'sd2147483648;
        return val;
    endfunction

    function automatic longint scaled_ratio(longint num, longint unsigned f, longint depth);
        longint unsigned a, zu, ip, q;
        a  = longint'(num < 0 ? -num : num) * f;
        zu = depth;
        ip = a / zu;
        if (ip >= 64'd65536) q = 64'd1 << 34;
        else q = (ip << 16) + (((a % zu) << 16) / zu);
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    task automatic project_pose(longint px, longint py, longint pz,
                                longint x, longint y, longint z, longint w);
        longint n, rot [3][3], num [3][3], p [3], d [3], u, v;
        t_pixel r;
        p = '{px, py, pz};
        n = x*x + y*y + z*z + w*w;
        num[0][0] = w*w + x*x - y*y - z*z;
        num[0][1] = 2 * (x*y - w*z);
        num[0][2] = 2 * (x*z + w*y);
        num[1][0] = 2 * (x*y + w*z);
        num[1][1] = w*w - x*x + y*y - z*z;
        num[1][2] = 2 * (y*z - w*x);
        num[2][0] = 2 * (x*z - w*y);
        num[2][1] = 2 * (y*z + w*x);
        num[2][2] = w*w - x*x - y*y + z*z;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                rot[i][j] = (n == 0) ? ((i == j) ? (64'sd1 << 30) : 0)
                                     : (num[i][j] * (64'sd1 << 30)) / n;
        for (int k = 0; k < N_TGT; k++) begin
            for (int i = 0; i < 3; i++) begin
                d[i] = 0;
                for (int j = 0; j < 3; j++)
                    d[i] += (rot[j][i] * (targets[k][j] - p[j])) >>> 30;
            end
            r.slot = SLOT_W'(k);
            r.behind = (d[0] <= 0);
            if (r.behind) begin
                u = 64'sd2147483647;
                v = 64'sd2147483647;
            end else begin
                u = sat32(scaled_ratio(-d[1], 64'(focal_x), d[0])
                          + (longint'(center_x) <<< 16));
                v = sat32(scaled_ratio(-d[2], 64'(focal_y), d[0])
                          + (longint'(center_y) <<< 16)
                          - (longint'(row_offset) <<< 16));
            end
            r.u = u[31:0];
            r.v = v[31:0];
            r.is_last = (k == N_TGT - 1);
            pixel_q = {pixel_q, r};
        end
    endtask

    // result checking
    always @(posedge i_clk) begin
        t_pixel e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pixel_q.size() == 0) begin
                $error("unexpected result slot %0d", o_slot);
                errors++;
            end else begin
                e = pixel_q.pop_front();
                if (o_slot !== e.slot) begin
                    $error("slot: expected %0d, got %0d", e.slot, o_slot); errors++;
                end
                if (o_pixel_u !== e.u) begin
                    $error("pixel_u: expected %0d, got %0d", e.u, o_pixel_u); errors++;
                end
                if (o_pixel_v !== e.v) begin
                    $error("pixel_v: expected %0d, got %0d", e.v, o_pixel_v); errors++;
                end
                if (o_behind_camera !== e.behind) begin
                    $error("behind_camera: expected %0b, got %0b", e.behind, o_behind_camera);
                    errors++;
                end
                if (o_last !== e.is_last) begin
                    $error("last: expected %0b, got %0b", e.is_last, o_last); errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver side
    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                i_out_ready <= 1'b1;
            end else begin
                stall = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_request(logic op, logic [3:0] idx,
                                logic signed [31:0] px, py, pz,
                                logic signed [15:0] qx, qy, qz, qw);
        int gap;
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_target_index <= idx;
        i_pos_x <= px; i_pos_y <= py; i_pos_z <= pz;
        i_quat_x <= qx; i_quat_y <= qy; i_quat_z <= qz; i_quat_w <= qw;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_STORE) begin
            if (idx < N_TGT) targets[idx] = '{longint'(px), longint'(py), longint'(pz)};
        end else begin
            project_pose(longint'(px), longint'(py), longint'(pz),
                         longint'(qx), longint'(qy), longint'(qz), longint'(qw));
        end
    endtask

    task automatic store_target(logic [3:0] idx, logic signed [31:0] px, py, pz);
        send_request(OP_STORE, idx, px, py, pz, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
    endtask

    task automatic send_pose(logic signed [31:0] px, py, pz,
                             logic signed [15:0] qx, qy, qz, qw);
        send_request(OP_POSE, 4'($urandom), px, py, pz, qx, qy, qz, qw);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_camera(logic [15:0] fx, fy, cx, cy, logic [11:0] ro);
        logic [15:0] vals [5];
        vals = '{fx, fy, cx, cy, {4'h0, ro}};
        for (int i = 0; i < 5; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= IDX_W'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        focal_x = fx; focal_y = fy; center_x = cx; center_y = cy; row_offset = ro;
    endtask

    function automatic logic signed [31:0] rand_pos();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $signed($urandom_range(0, 1 << 23)) - (1 << 22);
    endfunction

    task automatic send_random_pose();
        logic signed [15:0] q [4];
        case ($urandom_range(0, 7))
            0: q = '{16'sh0, 16'sh0, 16'sh0, 16'sh0};
            1, 2: q = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
            default: begin
                for (int i = 0; i < 3; i++)
                    q[i] = 16'($signed($urandom_range(0, 8000)) - 4000);
                q[3] = 16'(16384 - $urandom_range(0, 4000));
            end
        endcase
        send_pose(rand_pos(), rand_pos(), rand_pos(), q[0], q[1], q[2], q[3]);
    endtask

    task automatic test_store_extremes();
        store_target(4'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0);
        store_target(4'd1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF);
        store_target(4'd2, 32'sh0001_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        store_target(4'd3, 32'sh1234_5678, 32'sh1, 32'sh2);
        store_target(4'd15, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
        send_pose(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  16'sd0, 16'sd0, 16'sd0, 16'sd16384);
        send_pose(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                  -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_pose(32'shFFFF_FFFF, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    endtask

    task automatic test_pose_cases();
        // two targets in front and one behind, level and near the optical axis
        store_target(4'd0, 32'sh0005_0000, 32'sh0000_8000, 32'shFFFF_C000);
        store_target(4'd1, 32'sh0002_0000, 0, 0);
        store_target(4'd2, 32'shFFFE_0000, 0, 0);
        send_pose(0, 0, 0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_pose(0, 0, 0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384);
        send_pose(0, 0, 0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0);
        send_pose(0, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_pose(0, 0, 0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        // barely in front with a wide lateral offset drives the ratio past range
        store_target(4'd1, 32'sh0000_0001, 32'sh7000_0000, 32'sh9000_0000);
        send_pose(0, 0, 0, 16'sd0, 16'sd0, 16'sd0, 16'sd1);
        send_pose(32'sh0002_0000, 0, 0, 16'sd0, 16'sd0, 16'sd0, -16'sd5);
        send_pose(0, 0, 0, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
    endtask

    task automatic test_camera_settings();
        logic [15:0] fx [4] = '{16'hFFFF, 16'd1, 16'd0, 16'd559};
        logic [15:0] cx [4] = '{16'hFFFF, 16'd0, 16'd1234, 16'd490};
        logic [11:0] ro [4] = '{12'hFFF, 12'd0, 12'd77, 12'd180};
        for (int s = 0; s < 4; s++) begin
            wait_idle();
            set_camera(fx[s], fx[(s + 1) % 4], cx[s], cx[(s + 2) % 4], ro[s]);
            for (int i = 0; i < 4; i++) send_random_pose();
        end
    endtask

    task automatic test_random(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if (sent % 60 == 0) begin
                wait_idle();
                max_gap = ($urandom_range(0, 3) == 0) ? 0 : 18;
                set_camera(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           12'($urandom_range(0, 4095)));
            end
            if ($urandom_range(0, 9) == 0) begin
                send_request(1'($urandom), 4'($urandom), $urandom, $urandom, $urandom,
                             16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                sent++;
            end else begin
                for (int i = 0; i < $urandom_range(1, 3); i++) begin
                    store_target(4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                                : $urandom_range(0, 2)),
                                 rand_pos(), rand_pos(), rand_pos());
                    sent++;
                end
                for (int i = 0; i < $urandom_range(1, 3); i++) begin
                    send_random_pose();
                    sent++;
                end
            end
        end
        max_gap = 18;
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_cycles = 3000;
        for (int i = 0; i < 6; i++) send_random_pose();
        wait_idle();
    endtask

    initial begin
        focal_x = RST_FOCAL_X; focal_y = RST_FOCAL_Y;
        center_x = RST_CENTER_X; center_y = RST_CENTER_Y;
        row_offset = RST_ROW_OFFSET;
        foreach (targets[k, j]) targets[k][j] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_store_extremes();
        test_pose_cases();
        test_camera_settings();
        test_backpressure();
        test_random(320);
        wait_idle();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
